// ===== rtl/core/smawk_pkg.sv =====
// Package: transfer types and field codes for the SMAWK row minima block.
`default_nettype none
package smawk_pkg;

    localparam int CNT_W = 7;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int VAL_W = 32;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [CNT_W-1:0]        num_rows;
        logic [CNT_W-1:0]        num_cols;
        logic signed [VAL_W-1:0] entry_value;
    } item_t;

    typedef struct packed {
        logic             result_kind;
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] col_index;
        logic             last_answer;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/smawk_row_minima.sv =====
// Top level: SMAWK row minima sequencer with oracle query exchange.
//
// Usage: the item channel carries start items (row and column counts) and
// value items that answer the latest query. The result channel carries
// queries (row, column) for matrix entries and, at the end of a search, one
// answer per row with the last one flagged.
// A start item resets the search; a value item while idle is dropped.
// After each value transfer the sequencer runs control steps and registered
// memory reads within a level pass before the next query is loaded. Each
// level pass starts in S_LSTART and compacts its columns by stepping through
// S_CI and S_CW for each one. Each answer passes through S_FRD, S_FCAP and
// S_FEM, and waits in S_FEM while the result register is full.
// The item channel is stalled while the sequencer works; it is open only
// when idle or while a query is outstanding.
// The result register holds its item while the receiver stalls, and the
// sequencer waits before loading the next one.
// Reset (asynchronous, active low) returns the block to idle with no result
// pending and clears the level bounds. No clearing pass is needed.
`default_nettype none
module smawk_row_minima #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     item_valid,
    output logic                    item_stall,
    input  wire  smawk_pkg::item_t  item,
    output logic                    result_valid,
    input  wire                     result_stall,
    output smawk_pkg::result_t      result
);

    localparam int NLV = $clog2(MAX_ROWS) + 1;
    localparam int LVW = (NLV > 1) ? $clog2(NLV) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int IW  = (CNW > RNW + 1) ? CNW : RNW + 1;
    localparam int AW  = LVW + CW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LSTART = 5'd1;
    localparam logic [4:0] S_RI     = 5'd2;
    localparam logic [4:0] S_RJ     = 5'd3;
    localparam logic [4:0] S_RLOOP  = 5'd4;
    localparam logic [4:0] S_RID    = 5'd5;
    localparam logic [4:0] S_RLDR   = 5'd6;
    localparam logic [4:0] S_RA     = 5'd7;
    localparam logic [4:0] S_RB     = 5'd8;
    localparam logic [4:0] S_REND   = 5'd9;
    localparam logic [4:0] S_CI     = 5'd10;
    localparam logic [4:0] S_CW     = 5'd11;
    localparam logic [4:0] S_DRD    = 5'd12;
    localparam logic [4:0] S_DWR    = 5'd13;
    localparam logic [4:0] S_USTART = 5'd14;
    localparam logic [4:0] S_UC0    = 5'd15;
    localparam logic [4:0] S_UIND   = 5'd16;
    localparam logic [4:0] S_UINDC  = 5'd17;
    localparam logic [4:0] S_UROW   = 5'd18;
    localparam logic [4:0] S_UBND   = 5'd19;
    localparam logic [4:0] S_UMN    = 5'd20;
    localparam logic [4:0] S_USC    = 5'd21;
    localparam logic [4:0] S_USCC   = 5'd22;
    localparam logic [4:0] S_UX     = 5'd23;
    localparam logic [4:0] S_UDONE  = 5'd24;
    localparam logic [4:0] S_FRD    = 5'd25;
    localparam logic [4:0] S_FCAP   = 5'd26;
    localparam logic [4:0] S_FEM    = 5'd27;
    localparam logic [4:0] S_EMIT   = 5'd28;
    localparam logic [4:0] S_QWAIT  = 5'd29;

    logic [4:0]              state_reg;
    logic [4:0]              ret_reg;
    logic [RNW-1:0]          rows_reg;
    logic [RNW-1:0]          r_reg;
    logic [CNW-1:0]          cnt_reg;
    logic [CNW-1:0]          c_reg;
    logic [LVW-1:0]          lv_reg;
    logic [IW-1:0]           i_reg;
    logic [CNW-1:0]          k_reg;
    logic [CNW-1:0]          sp_reg;
    logic [CNW-1:0]          ind_reg;
    logic [CW-1:0]           id_reg;
    logic [CW-1:0]           j_reg;
    logic [RNW-1:0]          ldr_reg;
    logic [RNW-1:0]          lri_reg;
    logic                    copy_reg;
    logic                    bsel_reg;
    logic [CW-1:0]           cur_reg;
    logic [CW-1:0]           best_reg;
    logic [CW-1:0]           bound_reg;
    logic [CW-1:0]           ra0_reg;
    logic [RW-1:0]           row_reg;
    logic [RW-1:0]           qrow_reg;
    logic [CW-1:0]           qcol_reg;
    logic [CW-1:0]           hold_reg;
    logic signed [31:0]      val_reg;
    logic signed [31:0]      a_reg;
    logic signed [31:0]      mn_reg;
    logic [CNW-1:0]          lb_reg [NLV];
    logic                    out_valid_reg;
    smawk_pkg::result_t      out_reg;

    logic [CW-1:0]           cs_mem [2**AW];
    logic [RNW-1:0]          lr_mem [2**CW];
    logic [CW-1:0]           rs_mem [2**CW];
    logic [CW-1:0]           ra_mem [2**RW];
    logic [CW-1:0]           cs_q;
    logic [RNW-1:0]          lr_q;
    logic [CW-1:0]           rs_q;
    logic [CW-1:0]           ra_q;

    logic [AW-1:0]           cs_raddr;
    logic [AW-1:0]           cs_waddr;
    logic                    cs_we;
    logic [CW-1:0]           cs_wdata;
    logic [CW-1:0]           lr_raddr;
    logic [CW-1:0]           lr_waddr;
    logic                    lr_we;
    logic [RNW-1:0]          lr_wdata;
    logic [CW-1:0]           rs_raddr;
    logic                    rs_we;
    logic [RW-1:0]           ra_raddr;
    logic [RW-1:0]           ra_waddr;
    logic                    ra_we;
    logic [CW-1:0]           ra_wdata;

    logic [LVW-1:0]          lv_m1;
    logic [CW-1:0]           i_idx;
    logic [CW-1:0]           src_i;
    logic [CNW-1:0]          ind_p1;
    logic                    out_free;
    logic                    out_load;
    logic                    in_acc;
    logic                    keep;
    logic [RNW-1:0]          rows_clamp;
    logic [CNW-1:0]          cols_clamp;
    logic [RNW-1:0]          r_at_lv;
    logic [RNW-1:0]          r_at_m1;

    assign lv_m1    = lv_reg - 1'b1;
    assign i_idx    = i_reg[CW-1:0];
    assign src_i    = (lv_reg == '0) ? i_idx : cs_q;
    assign ind_p1   = ind_reg + 1'b1;
    assign out_free = !out_valid_reg || !result_stall;
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_FEM)) && out_free;
    assign item_stall = !((state_reg == S_IDLE) || (state_reg == S_QWAIT));
    assign in_acc   = item_valid && !item_stall;
    assign keep     = copy_reg || (lr_q < r_reg);
    assign r_at_lv  = RNW'(((rows_reg - 1'b1) >> lv_reg) + 1'b1);
    assign r_at_m1  = RNW'(((rows_reg - 1'b1) >> lv_m1) + 1'b1);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        if (item.num_rows == '0)
            rows_clamp = RNW'(1);
        else if (32'(item.num_rows) > 32'(MAX_ROWS))
            rows_clamp = RNW'(MAX_ROWS);
        else
            rows_clamp = RNW'(item.num_rows);
        if (item.num_cols == '0)
            cols_clamp = CNW'(1);
        else if (32'(item.num_cols) > 32'(MAX_COLS))
            cols_clamp = CNW'(MAX_COLS);
        else
            cols_clamp = CNW'(item.num_cols);
    end

    always_comb
    begin
        cs_raddr = {lv_m1, i_idx};
        lr_raddr = i_idx;
        rs_raddr = CW'(sp_reg - 1'b1);
        ra_raddr = RW'(k_reg);
        case (state_reg)
            S_RID:
            begin
                cs_raddr = {lv_m1, rs_q};
                lr_raddr = rs_q;
            end
            S_DRD:    cs_raddr = {lv_reg, CW'(0)};
            S_USTART: cs_raddr = {lv_m1, CW'(0)};
            S_UIND,
            S_USC:    cs_raddr = {lv_reg, ind_p1[CW-1:0]};
            S_UROW:
            begin
                cs_raddr = {lv_reg, CW'(c_reg - 1'b1)};
                ra_raddr = RW'((i_reg + 1'b1) << lv_reg);
            end
            default:  cs_raddr = {lv_m1, i_idx};
        endcase

        cs_we    = (state_reg == S_CW) && keep;
        cs_waddr = {lv_reg, k_reg[CW-1:0]};
        cs_wdata = src_i;

        lr_we    = 1'b0;
        lr_waddr = i_idx;
        lr_wdata = lri_reg;
        if (state_reg == S_RB && a_reg >= val_reg)
        begin
            lr_we    = 1'b1;
            lr_waddr = id_reg;
            lr_wdata = r_reg;
        end
        else if (state_reg == S_REND)
        begin
            lr_we = 1'b1;
        end

        rs_we = (state_reg == S_REND) && (lri_reg < r_reg);

        ra_we    = (state_reg == S_DWR) || (state_reg == S_UDONE);
        ra_waddr = (state_reg == S_DWR) ? RW'(0) : row_reg;
        ra_wdata = (state_reg == S_DWR) ? cs_q : best_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
            cs_mem[cs_waddr] <= cs_wdata;
        cs_q <= cs_mem[cs_raddr];
        if (lr_we)
            lr_mem[lr_waddr] <= lr_wdata;
        lr_q <= lr_mem[lr_raddr];
        if (rs_we)
            rs_mem[sp_reg[CW-1:0]] <= i_idx;
        rs_q <= rs_mem[rs_raddr];
        if (ra_we)
            ra_mem[ra_waddr] <= ra_wdata;
        ra_q <= ra_mem[ra_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            rows_reg      <= RNW'(1);
            r_reg         <= RNW'(1);
            cnt_reg       <= CNW'(1);
            c_reg         <= CNW'(1);
            lv_reg        <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            sp_reg        <= '0;
            ind_reg       <= '0;
            id_reg        <= '0;
            j_reg         <= '0;
            ldr_reg       <= '0;
            lri_reg       <= '0;
            copy_reg      <= 1'b0;
            bsel_reg      <= 1'b0;
            cur_reg       <= '0;
            best_reg      <= '0;
            bound_reg     <= '0;
            ra0_reg       <= '0;
            row_reg       <= '0;
            qrow_reg      <= '0;
            qcol_reg      <= '0;
            hold_reg      <= '0;
            val_reg       <= '0;
            a_reg         <= '0;
            mn_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int n = 0; n < NLV; n++)
                lb_reg[n] <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE,
                S_QWAIT:
                begin
                    if (in_acc)
                    begin
                        if (item.req_type == smawk_pkg::REQ_START)
                        begin
                            rows_reg  <= rows_clamp;
                            cnt_reg   <= cols_clamp;
                            lv_reg    <= '0;
                            state_reg <= S_LSTART;
                        end
                        else if (state_reg == S_QWAIT)
                        begin
                            val_reg   <= item.entry_value;
                            state_reg <= ret_reg;
                        end
                    end
                end
                S_LSTART:
                begin
                    r_reg    <= r_at_lv;
                    i_reg    <= '0;
                    k_reg    <= '0;
                    sp_reg   <= '0;
                    copy_reg <= !(32'(cnt_reg) > 32'(r_at_lv));
                    state_reg <= (32'(cnt_reg) > 32'(r_at_lv)) ? S_RI : S_CI;
                end
                S_RI:
                begin
                    if (i_reg == IW'(cnt_reg))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_CI;
                    end
                    else
                        state_reg <= S_RJ;
                end
                S_RJ:
                begin
                    j_reg     <= src_i;
                    lri_reg   <= '0;
                    state_reg <= S_RLOOP;
                end
                S_RLOOP:
                    state_reg <= (sp_reg == '0) ? S_REND : S_RID;
                S_RID:
                begin
                    id_reg    <= rs_q;
                    state_reg <= S_RLDR;
                end
                S_RLDR:
                begin
                    ldr_reg   <= lr_q;
                    qrow_reg  <= RW'(lr_q << lv_reg);
                    qcol_reg  <= (lv_reg == '0) ? id_reg : cs_q;
                    ret_reg   <= S_RA;
                    state_reg <= S_EMIT;
                end
                S_RA:
                begin
                    a_reg     <= val_reg;
                    qcol_reg  <= j_reg;
                    ret_reg   <= S_RB;
                    state_reg <= S_EMIT;
                end
                S_RB:
                begin
                    if (a_reg >= val_reg)
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        lri_reg   <= ldr_reg;
                        state_reg <= S_RLOOP;
                    end
                    else
                    begin
                        lri_reg   <= ldr_reg + 1'b1;
                        state_reg <= S_REND;
                    end
                end
                S_REND:
                begin
                    if (lri_reg < r_reg)
                        sp_reg <= sp_reg + 1'b1;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_RI;
                end
                S_CI:
                begin
                    if (i_reg == IW'(cnt_reg))
                    begin
                        lb_reg[lv_reg] <= k_reg;
                        cnt_reg        <= k_reg;
                        if (r_reg == RNW'(1))
                            state_reg <= S_DRD;
                        else
                        begin
                            lv_reg    <= lv_reg + 1'b1;
                            state_reg <= S_LSTART;
                        end
                    end
                    else
                        state_reg <= S_CW;
                end
                S_CW:
                begin
                    if (keep)
                        k_reg <= k_reg + 1'b1;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_CI;
                end
                S_DRD:
                    state_reg <= S_DWR;
                S_DWR:
                begin
                    ra0_reg   <= cs_q;
                    state_reg <= S_USTART;
                end
                S_USTART:
                begin
                    if (lv_reg == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        lv_reg    <= lv_m1;
                        r_reg     <= r_at_m1;
                        c_reg     <= lb_reg[lv_m1];
                        ind_reg   <= '0;
                        i_reg     <= IW'(1);
                        state_reg <= S_UC0;
                    end
                end
                S_UC0:
                begin
                    cur_reg   <= cs_q;
                    state_reg <= S_UIND;
                end
                S_UIND:
                    state_reg <= (ind_p1 < c_reg) ? S_UINDC : S_UROW;
                S_UINDC:
                begin
                    if (cs_q <= ra0_reg)
                    begin
                        ind_reg   <= ind_p1;
                        cur_reg   <= cs_q;
                        state_reg <= S_UIND;
                    end
                    else
                        state_reg <= S_UROW;
                end
                S_UROW:
                begin
                    if (i_reg >= IW'(r_reg))
                        state_reg <= S_USTART;
                    else
                    begin
                        row_reg   <= RW'(i_reg << lv_reg);
                        bsel_reg  <= (i_reg + 1'b1) < IW'(r_reg);
                        state_reg <= S_UBND;
                    end
                end
                S_UBND:
                begin
                    bound_reg <= bsel_reg ? ra_q : cs_q;
                    best_reg  <= cur_reg;
                    qrow_reg  <= row_reg;
                    qcol_reg  <= cur_reg;
                    ret_reg   <= S_UMN;
                    state_reg <= S_EMIT;
                end
                S_UMN:
                begin
                    mn_reg    <= val_reg;
                    state_reg <= S_USC;
                end
                S_USC:
                    state_reg <= (ind_p1 < c_reg) ? S_USCC : S_UDONE;
                S_USCC:
                begin
                    if (cs_q <= bound_reg)
                    begin
                        ind_reg   <= ind_p1;
                        cur_reg   <= cs_q;
                        qcol_reg  <= cs_q;
                        ret_reg   <= S_UX;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_UDONE;
                end
                S_UX:
                begin
                    if (val_reg < mn_reg)
                    begin
                        mn_reg   <= val_reg;
                        best_reg <= cur_reg;
                    end
                    state_reg <= S_USC;
                end
                S_UDONE:
                begin
                    i_reg     <= i_reg + IW'(2);
                    state_reg <= S_UROW;
                end
                S_FRD:
                    state_reg <= (32'(k_reg) == 32'(rows_reg)) ? S_IDLE : S_FCAP;
                S_FCAP:
                begin
                    hold_reg  <= ra_q;
                    state_reg <= S_FEM;
                end
                S_FEM:
                begin
                    if (out_free)
                    begin
                        out_reg.result_kind   <= smawk_pkg::KIND_ANSWER;
                        out_reg.row_index     <= smawk_pkg::ROW_W'(k_reg);
                        out_reg.col_index     <= smawk_pkg::COL_W'(hold_reg);
                        out_reg.last_answer   <= (32'(k_reg) + 1) == 32'(rows_reg);
                        k_reg                 <= k_reg + 1'b1;
                        state_reg             <= S_FRD;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg.result_kind   <= smawk_pkg::KIND_QUERY;
                        out_reg.row_index     <= smawk_pkg::ROW_W'(qrow_reg);
                        out_reg.col_index     <= smawk_pkg::COL_W'(qcol_reg);
                        out_reg.last_answer   <= 1'b0;
                        state_reg             <= S_QWAIT;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (out_valid_reg && state_reg == S_QWAIT))
        else $error("query not loaded into result register");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RLOOP) |-> (IW'(sp_reg) <= i_reg))
        else $error("leader stack deeper than scanned columns");

    a_compact_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CW) |-> (IW'(k_reg) <= i_reg))
        else $error("compaction count ahead of scan");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for smawk_row_minima: a predictor answers the queries and checks results.
`default_nettype none
module tb;

    localparam int LEVEL_CNT = 12;
    localparam int ROW_LIM = 64;
    localparam int COL_LIM = 64;
    localparam int VALUE_LOG_MAX = 4 * COL_LIM + 16 * ROW_LIM + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int ITEM_TARGET = 170;
    localparam int CNT_BITS = smawk_pkg::CNT_W;
    localparam int ROW_BITS = smawk_pkg::ROW_W;
    localparam int COL_BITS = smawk_pkg::COL_W;

    typedef enum int {MAT_MONGE, MAT_FLAT, MAT_NOISE, MAT_EXTREME} matrix_kind_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    smawk_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    smawk_pkg::result_t result;

    smawk_row_minima dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // search state kept by the predictor
    int unsigned col_store [LEVEL_CNT][COL_LIM];
    int unsigned lvl_bound [LEVEL_CNT];
    int unsigned leader [COL_LIM];
    int unsigned prune_stack [COL_LIM];
    int unsigned row_best [ROW_LIM];
    int unsigned work_cols [COL_LIM];
    int          value_log [$];
    int unsigned replay_idx;
    bit          searching;
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned query_row;
    int unsigned query_col;

    smawk_pkg::result_t expected_results [$];
    int          mismatch_count;
    bit          quiet;
    bit          long_hold_req;
    int          items_sent;

    matrix_kind_t mat_kind;
    int           mat_offset [ROW_LIM];
    int           mat_center [ROW_LIM];
    int           mat_scale;

    function automatic bit fetch_entry(int unsigned row, int unsigned col, output int v);
        if (replay_idx < value_log.size() && replay_idx < VALUE_LOG_MAX)
        begin
            v = value_log[replay_idx];
            replay_idx++;
            return 1'b1;
        end
        query_row = row;
        query_col = col;
        v = 0;
        return 1'b0;
    endfunction

    function automatic bit prune_level(int unsigned c, int unsigned lv, int unsigned r);
        int unsigned sp;
        int unsigned k;
        int unsigned j;
        int unsigned id;
        int unsigned row;
        int          a;
        int          b;
        sp = 0;
        k = 0;
        for (int unsigned i = 0; i < c; i++)
        begin
            j = work_cols[i];
            leader[i] = 0;
            while (sp > 0)
            begin
                id = prune_stack[sp - 1];
                row = leader[id] << lv;
                if (!fetch_entry(row, work_cols[id], a)) return 1'b0;
                if (!fetch_entry(row, j, b)) return 1'b0;
                if (a >= b)
                begin
                    sp--;
                    leader[i] = leader[id];
                    leader[id] = r;
                end
                else
                begin
                    leader[i] = leader[id] + 1;
                    break;
                end
            end
            if (leader[i] < r)
            begin
                prune_stack[sp] = i;
                sp++;
            end
        end
        for (int unsigned i = 0; i < c; i++)
        begin
            if (leader[i] < r)
            begin
                col_store[lv][k] = work_cols[i];
                k++;
            end
        end
        lvl_bound[lv] = k;
        return 1'b1;
    endfunction

    function automatic bit replay_search();
        int unsigned cnt;
        int unsigned r;
        int unsigned c;
        int unsigned ind;
        int unsigned bound;
        int unsigned best;
        int unsigned row;
        int          deep;
        int          mn;
        int          x;
        cnt = n_cols;
        deep = LEVEL_CNT - 1;
        replay_idx = 0;
        for (int unsigned i = 0; i < cnt; i++) work_cols[i] = i;
        for (int lv = 0; lv < LEVEL_CNT; lv++)
        begin
            r = ((n_rows - 1) >> lv) + 1;
            if (cnt > r)
            begin
                if (!prune_level(cnt, lv, r)) return 1'b0;
            end
            else
            begin
                for (int unsigned i = 0; i < cnt; i++) col_store[lv][i] = work_cols[i];
                lvl_bound[lv] = cnt;
            end
            cnt = lvl_bound[lv];
            if (r == 1)
            begin
                row_best[0] = col_store[lv][0];
                deep = lv;
                break;
            end
            for (int unsigned i = 0; i < cnt; i++) work_cols[i] = col_store[lv][i];
        end
        for (int lv = deep - 1; lv >= 0; lv--)
        begin
            r = ((n_rows - 1) >> lv) + 1;
            c = lvl_bound[lv];
            ind = 0;
            while (ind + 1 < c && col_store[lv][ind + 1] <= row_best[0]) ind++;
            for (int unsigned i = 1; i < r; i += 2)
            begin
                row = i << lv;
                bound = (i + 1 < r) ? row_best[(i + 1) << lv] : col_store[lv][c - 1];
                best = col_store[lv][ind];
                if (!fetch_entry(row, best, mn)) return 1'b0;
                while (ind + 1 < c && col_store[lv][ind + 1] <= bound)
                begin
                    ind++;
                    if (!fetch_entry(row, col_store[lv][ind], x)) return 1'b0;
                    if (x < mn)
                    begin
                        mn = x;
                        best = col_store[lv][ind];
                    end
                end
                row_best[row] = best;
            end
        end
        return 1'b1;
    endfunction

    function automatic int unsigned clamp_count(logic [CNT_BITS-1:0] v, int unsigned lim);
        int unsigned c;
        c = v;
        if (c == 0) c = 1;
        if (c > lim) c = lim;
        return c;
    endfunction

    function automatic void predict_minima(smawk_pkg::item_t it);
        smawk_pkg::result_t r;
        if (it.req_type == smawk_pkg::REQ_START)
        begin
            n_rows = clamp_count(it.num_rows, ROW_LIM);
            n_cols = clamp_count(it.num_cols, COL_LIM);
            value_log.delete();
            searching = 1'b1;
        end
        else
        begin
            if (!searching) return;
            if (value_log.size() < VALUE_LOG_MAX)
                value_log.insert(value_log.size(), it.entry_value);
        end
        if (!replay_search())
        begin
            r.result_kind = smawk_pkg::KIND_QUERY;
            r.row_index = query_row[ROW_BITS-1:0];
            r.col_index = query_col[COL_BITS-1:0];
            r.last_answer = 1'b0;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        searching = 1'b0;
        for (int unsigned k = 0; k < n_rows; k++)
        begin
            r.result_kind = smawk_pkg::KIND_ANSWER;
            r.row_index = k[ROW_BITS-1:0];
            r.col_index = row_best[k][COL_BITS-1:0];
            r.last_answer = (k + 1 == n_rows);
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    function automatic void new_matrix(matrix_kind_t kind);
        int c;
        mat_kind = kind;
        mat_scale = $urandom_range(1, 1000);
        c = 0;
        for (int i = 0; i < ROW_LIM; i++)
        begin
            if ($urandom_range(0, 2) == 0) c += $urandom_range(0, 4);
            mat_center[i] = c;
            mat_offset[i] = int'($urandom_range(0, 32'h7fff_ffff)) - 32'h4000_0000;
        end
    endfunction

    function automatic int matrix_entry(int unsigned row, int unsigned col);
        int d;
        case (mat_kind)
            MAT_MONGE:
            begin
                d = int'(col) - mat_center[row];
                return mat_offset[row] + mat_scale * d * d;
            end
            MAT_FLAT:    return mat_offset[0];
            MAT_NOISE:   return int'($urandom);
            default:     return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(smawk_pkg::item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_minima(it);
        items_sent++;
    endtask

    task automatic send_start(logic [CNT_BITS-1:0] rows, logic [CNT_BITS-1:0] cols);
        smawk_pkg::item_t it;
        it.req_type = smawk_pkg::REQ_START;
        it.num_rows = rows;
        it.num_cols = cols;
        it.entry_value = $urandom;
        send_item(it);
    endtask

    task automatic send_value(int v);
        smawk_pkg::item_t it;
        it.req_type = smawk_pkg::REQ_VALUE;
        it.num_rows = CNT_BITS'($urandom);
        it.num_cols = CNT_BITS'($urandom);
        it.entry_value = v;
        send_item(it);
    endtask

    // cut < 0 runs the search to its end; otherwise abandon it after cut values
    task automatic run_case(logic [CNT_BITS-1:0] rows, logic [CNT_BITS-1:0] cols,
                            matrix_kind_t kind, int cut);
        int n;
        n = 0;
        new_matrix(kind);
        send_start(rows, cols);
        while (searching && n != cut)
        begin
            send_value(matrix_entry(query_row, query_col));
            n++;
        end
    endtask

    task automatic test_single_cell();
        run_case(7'd1, 7'd1, MAT_MONGE, -1);
        run_case(7'd2, 7'd2, MAT_NOISE, -1);
    endtask

    task automatic test_count_limits();
        run_case(7'd0, 7'd0, MAT_NOISE, -1);
        run_case(7'd127, 7'd1, MAT_MONGE, -1);
        run_case(7'd1, 7'd127, MAT_MONGE, 6);
    endtask

    task automatic test_idle_values();
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
    endtask

    task automatic test_restart();
        run_case(7'd8, 7'd8, MAT_MONGE, 3);
        run_case(7'd3, 7'd4, MAT_MONGE, -1);
    endtask

    task automatic test_ties();
        run_case(7'd3, 7'd5, MAT_FLAT, -1);
        run_case(7'd5, 7'd2, MAT_FLAT, -1);
    endtask

    task automatic test_extremes();
        run_case(7'd64, 7'd2, MAT_EXTREME, 8);
        run_case(7'd2, 7'd64, MAT_NOISE, 8);
        run_case(7'd4, 7'd4, MAT_EXTREME, -1);
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        run_case(7'd5, 7'd5, MAT_MONGE, -1);
    endtask

    task automatic test_random();
        logic [CNT_BITS-1:0] rows;
        logic [CNT_BITS-1:0] cols;
        int                  cut;
        while (items_sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            rows = ($urandom_range(0, 5) == 0) ? CNT_BITS'($urandom_range(0, 127))
                                               : CNT_BITS'($urandom_range(1, 8));
            cols = ($urandom_range(0, 5) == 0) ? CNT_BITS'($urandom_range(0, 127))
                                               : CNT_BITS'($urandom_range(1, 8));
            cut = -1;
            if (rows > 8 || cols > 8)
                cut = int'($urandom_range(0, 10));
            case ($urandom_range(0, 9))
                0:       run_case(rows, cols, MAT_NOISE, int'($urandom_range(0, 6)));
                1:       run_case(rows, cols, MAT_NOISE, cut);
                2:       run_case(rows, cols, MAT_FLAT, cut);
                3:       send_value($urandom);
                default: run_case(rows, cols, MAT_MONGE, cut);
            endcase
        end
        quiet = 1'b0;
    endtask

    // result side: check each transfer and draw stalls
    initial
    begin
        int hold_left;
        int gap_left;
        smawk_pkg::result_t want;
        hold_left = 0;
        gap_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, kind", result.result_kind, -1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.result_kind !== want.result_kind)
                        report_mismatch("result_kind", result.result_kind, want.result_kind);
                    if (result.row_index !== want.row_index)
                        report_mismatch("row_index", result.row_index, want.row_index);
                    if (result.col_index !== want.col_index)
                        report_mismatch("col_index", result.col_index, want.col_index);
                    if (result.last_answer !== want.last_answer)
                        report_mismatch("last_answer", result.last_answer, want.last_answer);
                end
                gap_left = quiet ? 0 : $urandom_range(0, 7);
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            result_stall <= (hold_left > 0) || (gap_left > 0);
        end
    end

    always @(posedge clk)
    begin
        int idle_cycles;
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        items_sent = 0;
        searching = 1'b0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        result_stall <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_cell();
        test_count_limits();
        test_idle_values();
        test_restart();
        test_ties();
        test_extremes();
        test_backpressure();
        test_random();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
